/* rtl/light_mask_surface_cull_macros.svh */
`ifndef LIGHT_MASK_SURFACE_CULL_MACROS_SVH
`define LIGHT_MASK_SURFACE_CULL_MACROS_SVH
// assertion helpers
`define LMSC_ASSERT_IMP(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("lmsc check failed");
`define LMSC_ASSERT_NXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("lmsc check failed");
`endif

/* rtl/lmsc_pkg.sv */
package lmsc_pkg;
    localparam logic [2:0] MODE_LOAD   = 3'd0;
    localparam logic [2:0] MODE_PLANE  = 3'd1;
    localparam logic [2:0] MODE_BOX    = 3'd2;
    localparam logic [2:0] MODE_SPHERE = 3'd3;
    localparam logic [2:0] MODE_NOTEST = 3'd4;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [31:0] r;
    } light_t;

    typedef struct packed {
        logic [2:0]         mode;
        logic signed [31:0] v0;
        logic signed [31:0] v1;
        logic signed [31:0] v2;
        logic signed [31:0] v3;
        logic signed [31:0] v4;
        logic signed [31:0] v5;
    } part_t;
endpackage

/* rtl/lmsc_test_unit.sv */
// Multi-cycle miss test of one light against the current part.
// Step 0..2: three products (or box axes), step 3: final compare.
module lmsc_test_unit
    import lmsc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   start,
    input  light_t lt,
    input  part_t  pt,
    output logic   done,
    output logic   miss
);
    logic [2:0]          step_reg, step_next;
    logic                busy_reg, busy_next;
    logic signed [98:0]  acc_reg, acc_next;
    logic                miss_reg, miss_next;
    logic signed [32:0]  ma, mb;
    logic signed [65:0]  prod;
    logic signed [31:0]  bmin, bmax, bo;
    logic signed [33:0]  lo_v, hi_v;
    logic signed [98:0]  rsq, rr, dd;

    assign prod = ma * mb;

    always_comb
    begin
        ma = '0;
        mb = '0;
        bo = lt.x;
        bmin = pt.v0;
        bmax = pt.v3;
        case (step_reg)
            3'd0:
            begin
                bo = lt.x; bmin = pt.v0; bmax = pt.v3;
                if (pt.mode == MODE_PLANE)
                begin
                    ma = 33'(lt.x); mb = 33'(pt.v0);
                end
                else
                begin
                    ma = 33'(lt.x) - 33'(pt.v0); mb = ma;
                end
            end
            3'd1:
            begin
                bo = lt.y; bmin = pt.v1; bmax = pt.v4;
                if (pt.mode == MODE_PLANE)
                begin
                    ma = 33'(lt.y); mb = 33'(pt.v1);
                end
                else
                begin
                    ma = 33'(lt.y) - 33'(pt.v1); mb = ma;
                end
            end
            3'd2:
            begin
                bo = lt.z; bmin = pt.v2; bmax = pt.v5;
                if (pt.mode == MODE_PLANE)
                begin
                    ma = 33'(lt.z); mb = 33'(pt.v2);
                end
                else
                begin
                    ma = 33'(lt.z) - 33'(pt.v2); mb = ma;
                end
            end
            3'd3:
            begin
                ma = 33'(lt.r) + 33'(pt.v3); mb = ma;
            end
            default:
            begin
                ma = '0; mb = '0;
            end
        endcase
        lo_v = 34'(bo) - 34'(lt.r);
        hi_v = 34'(bo) + 34'(lt.r);
        rr = 99'(signed'(lt.r)) <<< 16;
        dd = acc_reg - (99'(signed'(pt.v3)) <<< 16);
        rsq = 99'(prod);

        step_next = step_reg;
        busy_next = busy_reg;
        acc_next  = acc_reg;
        miss_next = miss_reg;
        done = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            acc_next  = '0;
            miss_next = 1'b0;
        end
        else if (busy_reg)
        begin
            if (step_reg != 3'd3)
            begin
                acc_next = acc_reg + 99'(prod);
                if (pt.mode == MODE_BOX &&
                    (lo_v > 34'(bmax) || hi_v < 34'(bmin)))
                    miss_next = 1'b1;
                step_next = step_reg + 3'd1;
            end
            else
            begin
                busy_next = 1'b0;
                done = 1'b1;
                if (pt.mode == MODE_PLANE)
                    miss_next = (dd < -rr) || (dd > rr);
                else if (pt.mode == MODE_SPHERE)
                    miss_next = acc_reg > rsq;
            end
        end
    end

    assign miss = miss_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        miss_reg <= miss_next;
    end
endmodule

/* rtl/light_mask_surface_cull.sv */
// Sphere light culling; a load leaves the block ready for the next item. A
// plane, box or sphere part walks lights 0..min(num_lights,MAX_LIGHTS)-1
// through one shared test unit, testing each light whose mask bit is set and
// skipping each cleared bit; a no-test part skips the scan. The result sits
// in an output register, so the next item may be accepted while it waits;
// a last part holds in S_END while an earlier result is still waiting.
// s_tuser: mode[2:0]. s_tlast: is_last.
// s_tdata: is_first[0] drawable[1] start_mask[33:2] light_index[38:34]
//          v0..v5 [230:39], zero filled to 232 bits.
// m_tdata: light_mask[31:0] any_lit[32] lit_count[64:33] culled_count[96:65].
module light_mask_surface_cull
    import lmsc_pkg::*;
#(
    parameter int MAX_LIGHTS = 32
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [231:0] s_tdata,   // is_first, drawable, start_mask, light_index, v0..v5
    input  logic [2:0]   s_tuser,   // mode
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // light_mask, any_lit, lit_count, culled_count
    input  logic         cfg_we,
    input  logic [5:0]   cfg_wdata
);
    localparam int IW = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1;
    localparam logic [1:0] S_IDLE = 2'd0, S_SCAN = 2'd1, S_WAIT = 2'd2, S_END = 2'd3;

    logic [1:0]  st_reg, st_next;
    logic [5:0]  nl_reg;
    logic [31:0] mask_reg, lit_reg, cul_reg;
    logic [5:0]  idx_reg;
    part_t       pt_reg;
    logic        last_reg, draw_reg;
    logic        mv_reg;
    logic [103:0] md_reg;
    light_t      mem [MAX_LIGHTS];
    light_t      lt_reg;
    logic        start, done, miss;

    logic [2:0]  in_mode;
    logic        acc;
    logic        emit;
    logic [5:0]  n_lim;
    logic [31:0] fm;

    assign in_mode = s_tuser;
    assign s_tready = (st_reg == S_IDLE);
    assign acc = s_tvalid && s_tready;
    assign n_lim = (nl_reg > 6'(MAX_LIGHTS)) ? 6'(MAX_LIGHTS) : nl_reg;
    assign m_tvalid = mv_reg;
    assign m_tdata = md_reg;
    assign fm = draw_reg ? mask_reg : 32'd0;
    assign emit = (st_reg == S_END) && last_reg && (!mv_reg || m_tready);

    lmsc_test_unit u_test (.clk, .rst_n, .start, .lt(lt_reg), .pt(pt_reg),
                           .done, .miss);

    always_comb
    begin
        st_next = st_reg;
        start = 1'b0;
        case (st_reg)
            S_IDLE:
                if (acc && in_mode >= MODE_PLANE && in_mode <= MODE_NOTEST)
                    st_next = (in_mode == MODE_NOTEST) ? S_END : S_SCAN;
            S_SCAN:
                if (idx_reg >= n_lim)
                    st_next = S_END;
                else if (mask_reg[idx_reg[4:0]])
                begin
                    start = 1'b1;
                    st_next = S_WAIT;
                end
            S_WAIT:
                if (done)
                    st_next = S_SCAN;
            S_END:
                if (!mv_reg || m_tready || !last_reg)
                    st_next = S_IDLE;
            default:
                st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (acc && in_mode == MODE_LOAD && 32'(s_tdata[38:34]) < MAX_LIGHTS)
            mem[s_tdata[34 +: IW]] <= light_t'({s_tdata[70:39], s_tdata[102:71],
                                               s_tdata[134:103], s_tdata[166:135]});
        lt_reg <= mem[idx_reg[IW-1:0]];
        if (acc)
        begin
            pt_reg.mode <= in_mode;
            pt_reg.v0 <= s_tdata[70:39];
            pt_reg.v1 <= s_tdata[102:71];
            pt_reg.v2 <= s_tdata[134:103];
            pt_reg.v3 <= s_tdata[166:135];
            pt_reg.v4 <= s_tdata[198:167];
            pt_reg.v5 <= s_tdata[230:199];
            last_reg <= s_tlast;
            draw_reg <= s_tdata[1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            nl_reg <= '0;
            mask_reg <= '0;
            lit_reg <= '0;
            cul_reg <= '0;
            idx_reg <= '0;
            mv_reg <= 1'b0;
            md_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
            if (cfg_we)
                nl_reg <= cfg_wdata;
            if (emit)
                mv_reg <= 1'b1;
            else if (m_tready)
                mv_reg <= 1'b0;
            case (st_reg)
                S_IDLE:
                begin
                    idx_reg <= '0;
                    if (acc && s_tdata[0] && in_mode >= MODE_PLANE
                        && in_mode <= MODE_NOTEST)
                        mask_reg <= s_tdata[33:2];
                end
                S_SCAN:
                    if (idx_reg < n_lim && !mask_reg[idx_reg[4:0]])
                        idx_reg <= idx_reg + 6'd1;
                S_WAIT:
                    if (done)
                    begin
                        if (miss)
                            mask_reg[idx_reg[4:0]] <= 1'b0;
                        idx_reg <= idx_reg + 6'd1;
                    end
                S_END:
                    if (emit)
                    begin
                        if (fm != 0)
                        begin
                            lit_reg <= lit_reg + 32'd1;
                            md_reg <= {7'd0, cul_reg, lit_reg + 32'd1, 1'b1, fm};
                        end
                        else
                        begin
                            cul_reg <= cul_reg + 32'd1;
                            md_reg <= {7'd0, cul_reg + 32'd1, lit_reg, 1'b0, fm};
                        end
                    end
                default:
                    idx_reg <= '0;
            endcase
        end
    end
endmodule

/* rtl/lmsc_checker.sv */
`include "light_mask_surface_cull_macros.svh"
module lmsc_checker
    import lmsc_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [2:0]   s_tuser,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [103:0] m_tdata
);
    `LMSC_ASSERT_NXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `LMSC_ASSERT_IMP(a_any, m_tvalid, m_tdata[32] == (m_tdata[31:0] != 32'd0))
    `LMSC_ASSERT_IMP(a_pad, m_tvalid, m_tdata[103:97] == 7'd0)
    `LMSC_ASSERT_NXT(a_busy, s_tvalid && s_tready && s_tuser >= MODE_PLANE && s_tuser <= MODE_NOTEST, !s_tready)
endmodule

bind light_mask_surface_cull lmsc_checker u_lmsc_checker (.clk, .rst_n, .s_tvalid,
    .s_tready, .s_tuser, .m_tvalid, .m_tready, .m_tdata);
